// File: rtl/hee_pkg.sv
// package for the html escape / utf-8 byte encoder
// holds the mode codes, the queued transaction descriptor and queue sizing
// no dependencies
package hee_pkg;

  localparam logic [1:0] MODE_HTML7 = 2'd0;
  localparam logic [1:0] MODE_HTML8 = 2'd1;
  localparam logic [1:0] MODE_UTF8  = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam int MAX_BYTES = 6;
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [MAX_BYTES-1:0][7:0] byte_row_t;

  // one classified item: bytes in send order, first byte at index 0
  typedef struct packed {
    logic [CNT_W-1:0] nbytes;
    byte_row_t        bytes;
  } desc_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic  avail;
    desc_t desc;
  } qhead_t;

endpackage

// File: rtl/hee_front.sv
// front end: classifies one code point into the bytes it stands for
// uses hee_pkg for mode codes and the descriptor type
// pure combinational, registered by the queue behind it
module hee_front (
  input  logic [20:0]         code_point,
  input  logic                is_placeholder,
  input  logic [1:0]          mode,
  output logic                keep,
  output hee_pkg::desc_t      desc
);

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_P    = 8'h70;

  // &#NNN; with three decimal digits, tens by reciprocal multiply
  function automatic hee_pkg::byte_row_t dec_entity(input logic [7:0] v);
    logic [1:0]  h;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  t10;
    logic [3:0]  ones;
    hee_pkg::byte_row_t r;
    if (v >= 8'd200) begin
      h = 2'd2;
    end else if (v >= 8'd100) begin
      h = 2'd1;
    end else begin
      h = 2'd0;
    end
    rem  = 7'(v - 8'(h) * 8'd100);
    prod = {8'b0, rem} * 15'd205;
    tens = prod[14:11];
    t10  = 7'(tens) * 7'd10;
    ones = 4'(rem - t10);
    r[0] = CH_AMP;
    r[1] = CH_HASH;
    r[2] = CH_ZERO + {6'b0, h};
    r[3] = CH_ZERO + {4'b0, tens};
    r[4] = CH_ZERO + {4'b0, ones};
    r[5] = CH_SEMI;
    return r;
  endfunction

  logic [7:0] c8;
  logic       wide;

  assign c8   = code_point[7:0];
  assign wide = (mode == hee_pkg::MODE_UTF8) && (code_point >= 21'h80);
  assign keep = !is_placeholder;

  always_comb begin
    desc.nbytes = '0;
    desc.bytes  = '0;
    if (wide) begin
      priority if (code_point < 21'h800) begin
        desc.nbytes   = hee_pkg::CNT_W'(2);
        desc.bytes[0] = 8'hC0 | {3'b0, code_point[10:6]};
        desc.bytes[1] = 8'h80 | {2'b0, code_point[5:0]};
      end else if (code_point < 21'h10000) begin
        desc.nbytes   = hee_pkg::CNT_W'(3);
        desc.bytes[0] = 8'hE0 | {4'b0, code_point[15:12]};
        desc.bytes[1] = 8'h80 | {2'b0, code_point[11:6]};
        desc.bytes[2] = 8'h80 | {2'b0, code_point[5:0]};
      end else begin
        desc.nbytes   = hee_pkg::CNT_W'(4);
        desc.bytes[0] = 8'hF0 | {5'b0, code_point[20:18]};
        desc.bytes[1] = 8'h80 | {2'b0, code_point[17:12]};
        desc.bytes[2] = 8'h80 | {2'b0, code_point[11:6]};
        desc.bytes[3] = 8'h80 | {2'b0, code_point[5:0]};
      end
    end else begin
      priority if (c8 == CH_LT) begin
        desc.nbytes   = hee_pkg::CNT_W'(4);
        desc.bytes[0] = CH_AMP;
        desc.bytes[1] = CH_L;
        desc.bytes[2] = CH_T;
        desc.bytes[3] = CH_SEMI;
      end else if (c8 == CH_GT) begin
        desc.nbytes   = hee_pkg::CNT_W'(4);
        desc.bytes[0] = CH_AMP;
        desc.bytes[1] = CH_G;
        desc.bytes[2] = CH_T;
        desc.bytes[3] = CH_SEMI;
      end else if (c8 == CH_AMP) begin
        desc.nbytes   = hee_pkg::CNT_W'(5);
        desc.bytes[0] = CH_AMP;
        desc.bytes[1] = CH_A;
        desc.bytes[2] = CH_M;
        desc.bytes[3] = CH_P;
        desc.bytes[4] = CH_SEMI;
      end else if (c8 == CH_QUOT) begin
        desc.nbytes = hee_pkg::CNT_W'(6);
        desc.bytes  = dec_entity(c8);
      end else if (c8 >= 8'h20 && c8 <= 8'h7E) begin
        desc.nbytes   = hee_pkg::CNT_W'(1);
        desc.bytes[0] = c8;
      end else if (mode == hee_pkg::MODE_HTML7) begin
        desc.nbytes = hee_pkg::CNT_W'(6);
        desc.bytes  = dec_entity(c8);
      end else begin
        // control codes and high bytes go out raw
        desc.nbytes   = hee_pkg::CNT_W'(1);
        desc.bytes[0] = c8;
      end
    end
  end

endmodule

// File: rtl/hee_queue.sv
// short descriptor queue between the front end and the serializer
// uses hee_pkg for the descriptor type and depth
module hee_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hee_pkg::desc_t   push_desc,
  output logic             full,
  output hee_pkg::qhead_t  head,
  input  logic             pop
);

  hee_pkg::desc_t                 mem [hee_pkg::QUEUE_DEPTH];
  logic [hee_pkg::QPTR_W-1:0]     wr_ptr;
  logic [hee_pkg::QPTR_W-1:0]     rd_ptr;
  logic [hee_pkg::QCNT_W-1:0]     cnt;

  function automatic logic [hee_pkg::QPTR_W-1:0] ptr_inc(
    input logic [hee_pkg::QPTR_W-1:0] p);
    if (p == hee_pkg::QPTR_W'(hee_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full       = (cnt == hee_pkg::QCNT_W'(hee_pkg::QUEUE_DEPTH));
  assign head.avail = (cnt != '0);
  assign head.desc  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= hee_pkg::QCNT_W'(hee_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != '0)
    else $error("pop from empty queue");
`endif

endmodule

// File: rtl/hee_back.sv
// back end: serializes the head descriptor one byte per cycle while out_stall does not hold it
// uses hee_pkg for the queue head type; bytes leave through an output register
module hee_back (
  input  logic             clk,
  input  logic             rst,
  input  hee_pkg::qhead_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             last_byte
);

  logic [hee_pkg::IDX_W-1:0] idx;
  logic                      advance;
  logic                      at_last;

  assign advance = head.avail && (!out_valid || !out_stall);
  assign at_last = (idx == hee_pkg::IDX_W'(head.desc.nbytes - 1'b1));
  assign pop     = advance && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      idx       <= at_last ? '0 : idx + 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= head.desc.bytes[idx];
      last_byte <= at_last;
    end
  end

`ifndef SYNTH
  a_mid_item_has_head: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> head.avail)
    else $error("serializer mid transaction without a queued descriptor");
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    head.avail |-> head.desc.nbytes != '0)
    else $error("queued descriptor carries no bytes");
`endif

endmodule

// File: rtl/html_escape_utf8_encoder.sv
// Code points in, HTML text bytes out. Each accepted input transaction
// yields one to six output bytes (last_byte marks the final one), or none
// when is_placeholder is set. The front end classifies an item in the cycle
// it is accepted and drops it into a two-entry descriptor queue; the back
// end sends one byte per cycle, while out_stall does not hold it, from the
// queue head through an output register. An item is one byte for plain
// ASCII and raw bytes, four to six for entities, two to four for UTF-8.
// Input is taken every cycle while the queue has room; placeholders never
// reach the queue. Output mode (cfg_wr_data): 0 = 7-bit entities, 1 = 8-bit raw,
// 2 = UTF-8; a write of 3 is ignored. Change it only when idle.
//
// top level: instantiates hee_front, hee_queue and hee_back
// depends on hee_pkg
module html_escape_utf8_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] code_point,
  input  logic        is_placeholder,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  logic [1:0]      mode;
  logic            keep;
  logic            push;
  logic            full;
  logic            pop;
  hee_pkg::desc_t  front_desc;
  hee_pkg::qhead_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= hee_pkg::MODE_HTML7;
    end else if (cfg_wr_en && cfg_wr_data != hee_pkg::MODE_RSVD) begin
      mode <= cfg_wr_data;
    end
  end

  assign in_stall = full;
  assign push     = in_valid && !in_stall && keep;

  hee_front u_front (
    .code_point     (code_point),
    .is_placeholder (is_placeholder),
    .mode           (mode),
    .keep           (keep),
    .desc           (front_desc)
  );

  hee_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (front_desc),
    .full      (full),
    .head      (head),
    .pop       (pop)
  );

  hee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

`ifndef SYNTH
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    mode != hee_pkg::MODE_RSVD)
    else $error("reserved output mode latched");
`endif

endmodule

// File: bench/hee_checker.sv
// transaction checker for html_escape_utf8_encoder: tracks output_mode,
// predicts the byte text of every accepted code point and compares it in order
// depends on hee_pkg
module hee_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [20:0] code_point,
  input  logic        is_placeholder,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        last_byte,
  output int          mismatches,
  output int          bytes_pending,
  output int          chars_taken,
  output int          bytes_checked
);

  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_QUOT    = 8'h22;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  text_byte_t expected_text[$];
  logic [7:0] char_bytes[$];
  logic [1:0] cur_mode;

  function automatic void add_string(input string s);
    for (int i = 0; i < s.len(); i++) char_bytes.push_back(s[i]);
  endfunction

  function automatic void add_decimal(input logic [7:0] c);
    add_string("&#");
    char_bytes.push_back(ASCII_ZERO + c / 8'd100);
    char_bytes.push_back(ASCII_ZERO + (c / 8'd10) % 8'd10);
    char_bytes.push_back(ASCII_ZERO + c % 8'd10);
    add_string(";");
  endfunction

  function automatic void escape_byte(input logic [1:0] mode, input logic [7:0] c);
    unique case (c)
      CH_LT:   add_string("&lt;");
      CH_GT:   add_string("&gt;");
      CH_AMP:  add_string("&amp;");
      CH_QUOT: add_decimal(c);
      default: begin
        if (c >= PRINT_LO && c <= PRINT_HI) char_bytes.push_back(c);
        else if (mode == hee_pkg::MODE_HTML7) add_decimal(c);
        else char_bytes.push_back(c);
      end
    endcase
  endfunction

  // fills expected_text with the bytes one code point stands for
  function automatic void predict_char(input logic [1:0] mode, input logic [20:0] cp);
    text_byte_t tb;
    char_bytes.delete();
    if (mode == hee_pkg::MODE_UTF8 && cp >= 21'h80) begin
      if (cp < 21'h800) begin
        char_bytes.push_back({3'b110, cp[10:6]});
        char_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        char_bytes.push_back({4'b1110, cp[15:12]});
        char_bytes.push_back({2'b10, cp[11:6]});
        char_bytes.push_back({2'b10, cp[5:0]});
      end else begin
        char_bytes.push_back({5'b11110, cp[20:18]});
        char_bytes.push_back({2'b10, cp[17:12]});
        char_bytes.push_back({2'b10, cp[11:6]});
        char_bytes.push_back({2'b10, cp[5:0]});
      end
    end else begin
      // byte modes only look at the low byte
      escape_byte(mode, cp[7:0]);
    end
    for (int i = 0; i < char_bytes.size(); i++) begin
      tb.data = char_bytes[i];
      tb.last = (i == char_bytes.size() - 1);
      expected_text.push_back(tb);
    end
  endfunction

  always @(posedge clk) begin
    text_byte_t exp_byte;
    if (rst) begin
      cur_mode = hee_pkg::MODE_HTML7;
      expected_text.delete();
    end else begin
      if (in_valid && !in_stall) begin
        chars_taken++;
        if (!is_placeholder) predict_char(cur_mode, code_point);
      end
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (expected_text.size() == 0) begin
          mismatches++;
          $error("out_byte: no byte expected, got %02h (last_byte %0b)", out_byte, last_byte);
        end else begin
          exp_byte = expected_text.pop_front();
          if (out_byte !== exp_byte.data) begin
            mismatches++;
            $error("out_byte: expected %02h, got %02h", exp_byte.data, out_byte);
          end
          if (last_byte !== exp_byte.last) begin
            mismatches++;
            $error("last_byte: expected %0b, got %0b", exp_byte.last, last_byte);
          end
        end
      end
      // the reserved mode code leaves the mode as it was
      if (cfg_wr_en && cfg_wr_data != hee_pkg::MODE_RSVD) cur_mode = cfg_wr_data;
    end
    bytes_pending = expected_text.size();
  end

endmodule

// File: bench/tb_html_escape_utf8_encoder.sv
// testbench top for html_escape_utf8_encoder: directed and random code points
// in every output mode under changing idle patterns; hee_checker does the checks
// depends on hee_pkg, hee_checker and the encoder rtl
module tb_html_escape_utf8_encoder;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_CHARS = 252;
  localparam int SEGMENTS     = 3;

  localparam logic [20:0] CH_LT   = 21'h3C;
  localparam logic [20:0] CH_GT   = 21'h3E;
  localparam logic [20:0] CH_AMP  = 21'h26;
  localparam logic [20:0] CH_QUOT = 21'h22;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = hee_pkg::MODE_HTML7;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [20:0] code_point = '0;
  logic        is_placeholder = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;
  int mismatches, bytes_pending, chars_taken, bytes_checked;

  html_escape_utf8_encoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .code_point     (code_point),
    .is_placeholder (is_placeholder),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .last_byte      (last_byte)
  );

  hee_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .code_point     (code_point),
    .is_placeholder (is_placeholder),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .last_byte      (last_byte),
    .mismatches     (mismatches),
    .bytes_pending  (bytes_pending),
    .chars_taken    (chars_taken),
    .bytes_checked  (bytes_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < rx_idle_pct);
  end

  // ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_html_escape_utf8_encoder: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [20:0] cp, input logic ph);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    code_point     = cp;
    is_placeholder = ph;
    do @(posedge clk); while (in_stall);
  endtask

  // all bytes out, then a pause for anything still in the pipe
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [20:0] random_code();
    unique case ($urandom_range(5))
      0: return 21'($urandom_range(8'h7F));
      1: begin
        unique case ($urandom_range(3))
          0:       return CH_LT;
          1:       return CH_GT;
          2:       return CH_AMP;
          default: return CH_QUOT;
        endcase
      end
      2: return 21'($urandom_range(8'hFF, 8'h80));
      3: return 21'($urandom_range(21'h7FF, 21'h100));
      4: return 21'($urandom_range(21'hFFFF, 21'h800));
      default: return 21'($urandom_range(21'h1FFFFF, 21'h10000));
    endcase
  endfunction

  initial begin
    logic [20:0] html7_codes[] = '{CH_LT, CH_GT, CH_AMP, CH_QUOT, 21'h41, 21'h20,
                                   21'h7E, 21'h7F, 21'h00, 21'hFF, 21'h1FFF3C};
    logic [20:0] html8_codes[] = '{21'h00, 21'hFF, 21'h1F, CH_QUOT, 21'h12380};
    logic [20:0] utf8_codes[]  = '{21'h7F, 21'h0A, CH_LT, 21'h80, 21'h7FF, 21'h800,
                                   21'hFFFF, 21'h10000, 21'h1FFFFF};
    logic [1:0]  m;
    logic [20:0] cp;
    logic        ph;
    int          sent;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: escapes, printable edges, controls, wide codes, utf-8 lengths
    set_mode(hee_pkg::MODE_HTML7);
    foreach (html7_codes[i]) send_char(html7_codes[i], 1'b0);
    send_char(21'h1FFFFF, 1'b1);
    set_mode(hee_pkg::MODE_HTML8);
    foreach (html8_codes[i]) send_char(html8_codes[i], 1'b0);
    set_mode(hee_pkg::MODE_UTF8);
    foreach (utf8_codes[i]) send_char(utf8_codes[i], 1'b0);
    // reserved code must leave utf-8 in place
    set_mode(hee_pkg::MODE_RSVD);
    send_char(21'hE9, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 48 : 0;
      rx_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 30 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        m = 2'((seg + phase) % 3);
        set_mode(m);
        if ($urandom_range(3) == 0) set_mode(hee_pkg::MODE_RSVD);
        sent = 0;
        while (sent < RANDOM_CHARS / (3 * SEGMENTS)) begin
          ph = ($urandom_range(99) < 8);
          cp = random_code();
          send_char(cp, ph);
          sent++;
        end
      end
    end

    settle();
    $display("covered %0d input transactions and %0d output bytes", chars_taken, bytes_checked);
    $display("in 7-bit, 8-bit and utf-8 modes with both sides idling in turn and neither");
    if (mismatches == 0) begin
      $display("tb_html_escape_utf8_encoder: PASS");
    end else begin
      $display("tb_html_escape_utf8_encoder: FAIL");
    end
    $finish;
  end

endmodule
